FILE: design/dfd_pkg.sv
package dfd_pkg;

  localparam int unsigned TRACKER_ENTRIES_DEFAULT = 32;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FLOOD_THRESHOLD = 8'd1;

  localparam logic [31:0] WINDOW_LENGTH_RESET   = 32'd1000000;
  localparam logic [15:0] FLOOD_THRESHOLD_RESET = 16'd10;

  typedef struct packed {
    logic [47:0] source_addr;
    logic [47:0] dest_addr;
    logic [7:0]  radio_channel;
    logic [63:0] event_time_us;
  } event_item_t;

  typedef struct packed {
    logic [47:0] alert_source;
    logic [47:0] alert_dest;
    logic [15:0] alert_count;
    logic [63:0] alert_window_start;
    logic [7:0]  alert_channel;
    logic [63:0] alert_time;
  } alert_item_t;

  typedef struct packed {
    logic [47:0] source;
    logic [15:0] count;
    logic [63:0] window_start;
  } tracker_entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic calc;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_more;
    logic scan_done;
    logic out_block;
  } dp_status_t;

endpackage

FILE: design/dfd_ctrl.sv
module dfd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                event_valid,
  output logic                event_ready,
  input  dfd_pkg::dp_status_t status,
  output dfd_pkg::dp_cmd_t    cmd
);
  import dfd_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_CALC   = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign event_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        if (event_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = status.rd_more;
        if (status.scan_done) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold while an alert would overwrite one not yet taken
        if (!status.out_block) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/dfd_dp.sv
module dfd_dp #(
  parameter int unsigned TRACKER_ENTRIES = dfd_pkg::TRACKER_ENTRIES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dfd_pkg::event_item_t                event_item,
  output dfd_pkg::alert_item_t                alert_item,
  output logic                                alert_valid,
  input  logic                                alert_ready,
  input  logic                                cfg_valid,
  input  logic [dfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dfd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  dfd_pkg::dp_cmd_t                    cmd,
  output dfd_pkg::dp_status_t                 status
);
  import dfd_pkg::*;

  localparam int unsigned IdxW = (TRACKER_ENTRIES > 1) ? $clog2(TRACKER_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TRACKER_ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TRACKER_ENTRIES - 1);
  localparam logic [CntW-1:0] NumEntries = CntW'(TRACKER_ENTRIES);

  logic [31:0] window_length;
  logic [15:0] threshold;

  tracker_entry_t mem [TRACKER_ENTRIES];
  logic [TRACKER_ENTRIES-1:0] entry_valid;

  event_item_t item;

  logic [CntW-1:0] rd_cnt;
  logic            cmp_en;
  logic [IdxW-1:0] cmp_idx;
  tracker_entry_t  rd_q;

  logic            hit;
  logic [IdxW-1:0] hit_idx;
  logic [15:0]     hit_cnt;
  logic [63:0]     hit_ws;
  logic            have_free;
  logic [IdxW-1:0] free_idx;
  logic            have_vict;
  logic [IdxW-1:0] vict_idx;
  logic [63:0]     vict_ws;

  logic [IdxW-1:0] e_idx;
  logic [15:0]     base_cnt;
  logic [63:0]     base_ws;
  logic            expired;

  logic [15:0]     cnt_inc;
  logic [63:0]     ws_cur;
  logic            alert;
  logic [63:0]     age;

  assign age     = item.event_time_us - hit_ws;
  assign cnt_inc = (expired ? 16'd0 : base_cnt) + 16'd1;
  assign ws_cur  = expired ? item.event_time_us : base_ws;
  assign alert   = (cnt_inc >= threshold);

  assign status.rd_more   = (rd_cnt < NumEntries);
  assign status.scan_done = cmp_en && (cmp_idx == LastIdx);
  assign status.out_block = alert && alert_valid && !alert_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RESET;
      threshold     <= FLOOD_THRESHOLD_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WINDOW_LENGTH) begin
        window_length <= cfg_data;
      end else if (cfg_index == REG_FLOOD_THRESHOLD) begin
        threshold <= cfg_data[15:0];
      end
    end
  end

  // tracker table
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_q <= mem[rd_cnt[IdxW-1:0]];
    end
    if (cmd.commit) begin
      mem[e_idx] <= '{source:       item.source_addr,
                      count:        alert ? 16'd0 : cnt_inc,
                      window_start: alert ? item.event_time_us : ws_cur};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.commit) begin
      entry_valid[e_idx] <= 1'b1;
    end
  end

  // scan: one read per cycle, each entry compared in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item      <= event_item;
      rd_cnt    <= '0;
      hit       <= 1'b0;
      have_free <= 1'b0;
      have_vict <= 1'b0;
    end else begin
      if (cmd.scan_rd) begin
        rd_cnt  <= rd_cnt + CntW'(1);
        cmp_idx <= rd_cnt[IdxW-1:0];
      end
      if (cmp_en) begin
        if (entry_valid[cmp_idx]) begin
          if (rd_q.source == item.source_addr) begin
            hit     <= 1'b1;
            hit_idx <= cmp_idx;
            hit_cnt <= rd_q.count;
            hit_ws  <= rd_q.window_start;
          end
          // oldest window start, lowest index on a tie
          if (!have_vict || (rd_q.window_start < vict_ws)) begin
            have_vict <= 1'b1;
            vict_idx  <= cmp_idx;
            vict_ws   <= rd_q.window_start;
          end
        end else if (!have_free) begin
          have_free <= 1'b1;
          free_idx  <= cmp_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      if (hit) begin
        e_idx    <= hit_idx;
        base_cnt <= hit_cnt;
        base_ws  <= hit_ws;
        expired  <= (age > {32'd0, window_length});
      end else begin
        e_idx    <= have_free ? free_idx : vict_idx;
        base_cnt <= 16'd0;
        base_ws  <= item.event_time_us;
        expired  <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      alert_valid <= 1'b0;
    end else if (cmd.commit && alert) begin
      alert_valid <= 1'b1;
    end else if (alert_ready) begin
      alert_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && alert) begin
      alert_item <= '{alert_source:       item.source_addr,
                      alert_dest:         item.dest_addr,
                      alert_count:        cnt_inc,
                      alert_window_start: ws_cur,
                      alert_channel:      item.radio_channel,
                      alert_time:         item.event_time_us};
    end
  end

endmodule

FILE: design/deauth_flood_detector.sv
// deauth flood detector: per-source fixed-window event counter
// event channel (event_valid/event_ready/event_item): one deauth frame per
// transaction, taken only while the block is idle.
// alert channel (alert_valid/alert_ready/alert_item): at most one alert per
// event, held in an output register until taken.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; index 0
// is the window length, index 1 the threshold, other indexes are ignored.
// events are accepted one at a time, with no new event taken until the
// last one is done: the tracker table has a single read port, every entry is
// read in turn and compared in the cycle after its read, the calc step picks
// the entry and checks window expiry, the commit step updates it and loads
// any alert, and the block then returns to idle with event_ready high to
// take the next event. alert_valid rises at the update edge.
// if the alert register is still full when a new alert is due, the update
// waits until the receiver takes the old one; the next event is not accepted
// meanwhile. an event that raises no alert never waits on the receiver.
// reset is synchronous: it empties the table (valid bits only), drops any
// pending alert and restores the register defaults.
module deauth_flood_detector #(
  parameter int unsigned TRACKER_ENTRIES = dfd_pkg::TRACKER_ENTRIES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            event_valid,
  output logic                            event_ready,
  input  dfd_pkg::event_item_t            event_item,
  output logic                            alert_valid,
  input  logic                            alert_ready,
  output dfd_pkg::alert_item_t            alert_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dfd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  dfd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .status      (status),
    .cmd         (cmd)
  );

  dfd_dp #(
    .TRACKER_ENTRIES (TRACKER_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .event_item  (event_item),
    .alert_item  (alert_item),
    .alert_valid (alert_valid),
    .alert_ready (alert_ready),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

FILE: test/deauth_flood_checker.sv
`timescale 1ns / 1ps
module deauth_flood_checker #(
  parameter int unsigned TRACKER_ENTRIES = dfd_pkg::TRACKER_ENTRIES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            event_valid,
  input  logic                            event_ready,
  input  dfd_pkg::event_item_t            event_item,
  input  logic                            alert_valid,
  input  logic                            alert_ready,
  input  dfd_pkg::alert_item_t            alert_item,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [dfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              failures,
  output int                              outstanding
);
  import dfd_pkg::*;

  logic        tracked    [TRACKER_ENTRIES];
  logic [47:0] trk_source [TRACKER_ENTRIES];
  logic [15:0] trk_count  [TRACKER_ENTRIES];
  logic [63:0] trk_start  [TRACKER_ENTRIES];
  logic [31:0] window_len;
  logic [15:0] threshold;

  alert_item_t expected_alerts[$];

  // one deauth frame into the tracker table, queueing the alert it raises
  function automatic void count_deauth(input event_item_t ev);
    int          hit;
    int          free_idx;
    int          oldest;
    logic [63:0] age;
    alert_item_t al;
    hit      = -1;
    free_idx = -1;
    oldest   = -1;
    for (int i = 0; i < TRACKER_ENTRIES; i++) begin
      if (tracked[i]) begin
        if (trk_source[i] == ev.source_addr) begin
          if (hit < 0) hit = i;
        end else if (oldest < 0 || trk_start[i] < trk_start[oldest]) begin
          oldest = i;
        end
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (hit < 0) begin
      // miss: first free slot, else evict the earliest window start
      hit = (free_idx >= 0) ? free_idx : oldest;
      tracked[hit]    = 1'b1;
      trk_source[hit] = ev.source_addr;
      trk_count[hit]  = '0;
      trk_start[hit]  = ev.event_time_us;
    end
    // wraps modulo 2^64, so a timestamp going backwards also restarts
    age = ev.event_time_us - trk_start[hit];
    if (age > {32'h0, window_len}) begin
      trk_start[hit] = ev.event_time_us;
      trk_count[hit] = '0;
    end
    trk_count[hit] = trk_count[hit] + 16'd1;
    if (trk_count[hit] >= threshold) begin
      al.alert_source       = ev.source_addr;
      al.alert_dest         = ev.dest_addr;
      al.alert_count        = trk_count[hit];
      al.alert_window_start = trk_start[hit];
      al.alert_channel      = ev.radio_channel;
      al.alert_time         = ev.event_time_us;
      expected_alerts.push_back(al);
      trk_start[hit] = ev.event_time_us;
      trk_count[hit] = '0;
    end
  endfunction

  function automatic int field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    int          bad;
    alert_item_t want;
    bad = 0;
    if (rst) begin
      for (int i = 0; i < TRACKER_ENTRIES; i++) tracked[i] = 1'b0;
      window_len = WINDOW_LENGTH_RESET;
      threshold  = FLOOD_THRESHOLD_RESET;
      expected_alerts.delete();
      failures    <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_LENGTH:   window_len = cfg_data;
          REG_FLOOD_THRESHOLD: threshold  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (alert_valid && alert_ready) begin
        if (expected_alerts.size() == 0) begin
          $display("%0t: unexpected alert transaction, expected none, actual %h",
                   $time, alert_item);
          bad++;
        end else begin
          want = expected_alerts.pop_front();
          bad += field_differs("alert_source", want.alert_source, alert_item.alert_source);
          bad += field_differs("alert_dest", want.alert_dest, alert_item.alert_dest);
          bad += field_differs("alert_count", want.alert_count, alert_item.alert_count);
          bad += field_differs("alert_window_start", want.alert_window_start,
                               alert_item.alert_window_start);
          bad += field_differs("alert_channel", want.alert_channel, alert_item.alert_channel);
          bad += field_differs("alert_time", want.alert_time, alert_item.alert_time);
        end
      end
      if (event_valid && event_ready) count_deauth(event_item);
      failures    <= failures + bad;
      outstanding <= expected_alerts.size();
    end
  end

endmodule

FILE: test/tb_deauth_flood_detector.sv
`timescale 1ns / 1ps
module tb_deauth_flood_detector;
  import dfd_pkg::*;

  localparam int unsigned ENTRIES = TRACKER_ENTRIES_DEFAULT;
  // settle long enough for an event that raises nothing to finish
  localparam int SETTLE_CYCLES = ENTRIES + 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 125;
  localparam int POOL_MAX      = 40;

  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNMAPPED = REG_FLOOD_THRESHOLD + CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_LAST_INDEX     = '1;

  localparam logic [47:0] ADDR_ZERO = 48'h0;
  localparam logic [47:0] ADDR_ONES = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] ADDR_A    = 48'h0123_4567_89AB;
  localparam logic [63:0] TIME_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;

  logic                   clk;
  logic                   rst;
  logic                   event_valid;
  logic                   event_ready;
  event_item_t            event_item;
  logic                   alert_valid;
  logic                   alert_ready;
  alert_item_t            alert_item;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int          failures;
  int          outstanding;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;
  logic [47:0] source_pool [POOL_MAX];
  logic [63:0] now;

  deauth_flood_detector #(.TRACKER_ENTRIES(ENTRIES)) dut (
    .clk(clk), .rst(rst),
    .event_valid(event_valid), .event_ready(event_ready), .event_item(event_item),
    .alert_valid(alert_valid), .alert_ready(alert_ready), .alert_item(alert_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  deauth_flood_checker #(.TRACKER_ENTRIES(ENTRIES)) alert_check (
    .clk(clk), .rst(rst),
    .event_valid(event_valid), .event_ready(event_ready), .event_item(event_item),
    .alert_valid(alert_valid), .alert_ready(alert_ready), .alert_item(alert_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (event_valid && event_ready) || (alert_valid && alert_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // alert receiver with random back-pressure
  initial begin
    int stall;
    alert_ready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        alert_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      alert_ready <= 1'b1;
      do @(posedge clk); while (alert_valid !== 1'b1);
    end
  end

  task automatic post_deauth(input logic [47:0] src, input logic [47:0] dst,
                             input logic [7:0] chan, input logic [63:0] at);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      event_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    event_valid <= 1'b1;
    event_item  <= '{source_addr: src, dest_addr: dst, radio_channel: chan,
                     event_time_us: at};
    do @(posedge clk); while (event_ready !== 1'b1);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // unmapped index last, so a bad decode would clobber a live setting
  task automatic configure(input logic [31:0] win, input logic [31:0] thr_word);
    write_reg(REG_WINDOW_LENGTH, win);
    write_reg(REG_FLOOD_THRESHOLD, thr_word);
    write_reg(CFG_INDEX_W'($urandom_range(REG_FIRST_UNMAPPED, REG_LAST_INDEX)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic quiesce();
    event_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int p);
    logic [31:0] win;
    logic [15:0] thr;
    logic [63:0] step;
    logic [47:0] src;
    int          pool_size;
    int          pick;
    case ($urandom_range(0, 5))
      0:       win = 32'h0;
      1:       win = 32'hFFFF_FFFF;
      2:       win = $urandom;
      default: win = $urandom_range(16, 4000);
    endcase
    thr = (p == 0) ? 16'd1 : 16'($urandom_range(2, 6));
    configure(win, {16'($urandom), thr});
    case (p % 3)
      0:       pool_size = 4;
      1:       pool_size = 16;
      default: pool_size = POOL_MAX;
    endcase
    for (int i = 0; i < pool_size; i++) source_pool[i] = {16'($urandom), $urandom};
    no_idle = (p == 3) || ($urandom_range(0, 3) == 0);
    step = 64'(win) / (64'(thr) * 64'($urandom_range(1, 8))) + 64'd1;
    // some phases run across the 2^64 timestamp wrap
    if ($urandom_range(0, 1)) now = {$urandom, $urandom};
    else now = TIME_MAX - 64'(PHASE_ITEMS) * step;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) now = now - 64'($urandom_range(1, 1000));
      else if (pick < 6) now = now + 64'(win) + 64'($urandom_range(1, 50));
      else now = now + ({$urandom, $urandom} % (step + 64'd1));
      pick = $urandom_range(0, 99);
      if (pick < 5) src = {16'($urandom), $urandom};
      else if (pick < 60) src = source_pool[$urandom_range(0, 2)];
      else src = source_pool[$urandom_range(0, pool_size - 1)];
      post_deauth(src, {16'($urandom), $urandom}, 8'($urandom), now);
    end
  endtask

  initial begin
    rst         = 1'b1;
    event_valid = 1'b0;
    event_item  = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_WINDOW_LENGTH;
    cfg_data    = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: ten frames from one source straddling the timestamp wrap
    for (int i = 0; i < 10; i++)
      post_deauth(ADDR_ONES, i[0] ? ADDR_ONES : ADDR_ZERO, i[0] ? 8'hFF : 8'h00,
                  64'hFFFF_FFFF_FFFF_FFF8 + 64'(i));
    post_deauth(ADDR_ZERO, ADDR_ONES, 8'h5A, TIME_MAX);

    // zero-length window: only equal timestamps share a window
    quiesce();
    configure(32'h0, 32'd2);
    post_deauth(ADDR_A, ADDR_ZERO, 8'd1, 64'd500);
    post_deauth(ADDR_A, ADDR_ONES, 8'd2, 64'd500);
    post_deauth(ADDR_A, ADDR_ZERO, 8'd3, 64'd501);
    post_deauth(ADDR_A, ADDR_ONES, 8'd4, 64'd400);
    post_deauth(ADDR_A, ADDR_ZERO, 8'd5, 64'd400);

    // threshold of zero (upper data bits set), longest window
    quiesce();
    configure(32'hFFFF_FFFF, 32'hFFFF_0000);
    post_deauth(ADDR_A, ADDR_ONES, 8'hFF, 64'd7);
    post_deauth(ADDR_ZERO, ADDR_ZERO, 8'h00, TIME_MAX);

    // largest threshold: nothing fires
    quiesce();
    configure(32'd1000, 32'h0000_FFFF);
    post_deauth(ADDR_A, ADDR_ONES, 8'h81, 64'd10);
    post_deauth(ADDR_A, ADDR_ZERO, 8'h7E, 64'd20);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiesce();
      random_phase(p);
    end
    quiesce();

    if (failures == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/dfd_pkg.sv
design/dfd_ctrl.sv
design/dfd_dp.sv
design/deauth_flood_detector.sv
test/deauth_flood_checker.sv
test/tb_deauth_flood_detector.sv
